// File: rtl/linear_hash_table_engine_defines.svh
// Assertion macros for the linear hash table engine.
`ifndef LINEAR_HASH_TABLE_ENGINE_DEFINES_SVH
`define LINEAR_HASH_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define LHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define LHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lht_pkg.sv
// Shared types, codes and widths of the linear hash table engine.
package lht_pkg;

  localparam int OP_W      = 3;
  localparam int KEY_W     = 32;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int ITEMS_W   = 13;
  localparam int SLOTS_W   = 9;
  localparam int IBK_W     = 9;
  localparam int BSZ_W     = 7;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_SLOTS_DEF  = 256;
  localparam int SLOT_DEPTH_DEF = 16;

  localparam logic [IBK_W-1:0] IBK_RESET = 9'd32;
  localparam logic [BSZ_W-1:0] BSZ_RESET = 7'd8;

  localparam logic [CFG_IDX_W-1:0] REG_INIT_BUCKETS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_SIZE  = 1'd1;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [OP_W-1:0] OP_GROW   = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS    = 2'd3;

  typedef struct packed {
    logic done;
    logic odd;
  } div_stat_t;

endpackage

// File: rtl/lht_if.sv
// Request and response channel interfaces.
interface lht_req_if;
  logic                      valid;
  logic                      ready;
  logic [lht_pkg::OP_W-1:0]  operation;
  logic [lht_pkg::KEY_W-1:0] key;
  logic [lht_pkg::DATA_W-1:0] data_in;
  modport source (output valid, operation, key, data_in, input ready);
  modport sink   (input valid, operation, key, data_in, output ready);
endinterface

interface lht_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lht_pkg::STATUS_W-1:0]  status;
  logic [lht_pkg::DATA_W-1:0]    data_out;
  logic [lht_pkg::ITEMS_W-1:0]   item_total;
  logic [lht_pkg::SLOTS_W-1:0]   slot_total;
  modport source (output valid, status, data_out, item_total, slot_total, input ready);
  modport sink   (input valid, status, data_out, item_total, slot_total, output ready);
endinterface

// File: rtl/lht_div.sv
// Bit-serial restoring divider: key mod bucket count plus quotient parity.
module lht_div #(
  parameter int SW = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [lht_pkg::KEY_W-1:0] dividend,
  input  logic [SW-1:0]             divisor,
  output logic [SW-1:0]             rem,
  output lht_pkg::div_stat_t        stat
);
  import lht_pkg::*;

  localparam int CNT_W = $clog2(KEY_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [KEY_W-1:0] dvd;
  logic [SW-1:0]    dsr;
  logic [SW:0]      trial;
  logic             qbit;

  assign trial = {rem, dvd[KEY_W-1]};
  assign qbit  = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd      <= {dvd[KEY_W-2:0], 1'b0};
        rem      <= qbit ? SW'(trial - {1'b0, dsr}) : trial[SW-1:0];
        stat.odd <= qbit;
        cnt      <= cnt + 1'b1;
        if (cnt == CNT_W'(KEY_W - 1)) begin
          busy      <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/linear_hash_table_engine.sv
// Linear hashing key/data table. One operation at a time: ready drops after
// each accepted beat until its response is registered. Get, remove and insert
// run one serial division (key mod base bucket count) and then scan the slot
// entry by entry; clear, create and unused codes go straight to the response.
// A split (grow, or an insert over the load threshold) rehashes every entry of
// the slot being split through the same divider. Entry and fill stores are
// one-read one-write memories with registered reads; fill counts carry one
// valid flop per slot, so reset, clear and create need no clearing pass.
`include "linear_hash_table_engine_defines.svh"
module linear_hash_table_engine #(
  parameter int MAX_SLOTS  = lht_pkg::MAX_SLOTS_DEF,
  parameter int SLOT_DEPTH = lht_pkg::SLOT_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  lht_req_if.sink                       req,
  lht_rsp_if.source                     rsp,
  input  logic                          cfg_write,
  input  logic [lht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lht_pkg::CFG_W-1:0]     cfg_data
);
  import lht_pkg::*;

  localparam int SW   = $clog2(MAX_SLOTS + 1);
  localparam int AW   = $clog2(MAX_SLOTS);
  localparam int FW   = $clog2(SLOT_DEPTH + 1);
  localparam int NENT = MAX_SLOTS * SLOT_DEPTH;
  localparam int MW   = (NENT > 1) ? $clog2(NENT) : 1;
  localparam int CW   = $clog2(NENT + 2);
  localparam int PW   = SW + BSZ_W;
  localparam int BASE_RESET = (32 < MAX_SLOTS) ? 32 : MAX_SLOTS;

  localparam logic [4:0] S_IDLE = 5'd0,  S_THR  = 5'd1,  S_CMP   = 5'd2,  S_SPL = 5'd3,
                         S_SFIL = 5'd4,  S_SRD  = 5'd5,  S_SRDW  = 5'd6,  S_SDIV = 5'd7,
                         S_SWO  = 5'd8,  S_SWN  = 5'd9,  S_HASH  = 5'd10, S_HASHW = 5'd11,
                         S_FILW = 5'd12, S_SCAN = 5'd13, S_SCANW = 5'd14, S_RMB = 5'd15,
                         S_RESP = 5'd16;

  logic [4:0]          state;
  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    key_q;
  logic [DATA_W-1:0]   data_q;
  logic [SW-1:0]       base;
  logic [AW-1:0]       sp;
  logic [CW-1:0]       count;
  logic [IBK_W-1:0]    ibk;
  logic [BSZ_W-1:0]    bsz;
  logic [STATUS_W-1:0] status_q;
  logic [DATA_W-1:0]   dout_q;
  logic [PW-1:0]       prod;
  logic [AW-1:0]       old_s, fresh_s, slot_q;
  logic [FW-1:0]       nfill, eidx, keep, fcnt, fill_q;

  // entry store
  logic [KEY_W-1:0]  ent_key [NENT];
  logic [DATA_W-1:0] ent_dat [NENT];
  logic              ent_re, ent_we;
  logic [MW-1:0]     ent_raddr, ent_waddr;
  logic [KEY_W-1:0]  ent_wkey, rd_key;
  logic [DATA_W-1:0] ent_wdat, rd_dat;

  // fill store
  logic [FW-1:0]        fill_mem [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] fill_valid;
  logic                 fill_we, fill_clr;
  logic [AW-1:0]        fill_raddr, fill_waddr;
  logic [FW-1:0]        fill_wdata, fill_rd, fill_eff;
  logic                 fill_rv;

  // divider
  logic             div_start;
  logic [KEY_W-1:0] div_dvd;
  logic [SW-1:0]    div_rem;
  div_stat_t        div_st;
  logic [AW-1:0]    slot_c;
  logic [SW-1:0]    slot_sum;

  logic [SW-1:0]    used;
  logic [SW-1:0]    sp_inc;
  logic [63:0]      load_w, cap_w, items_w, slots_w;

  lht_div #(.SW(SW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (base),
    .rem      (div_rem),
    .stat     (div_st)
  );

  assign used     = base + SW'(sp);
  assign sp_inc   = SW'(sp) + 1'b1;
  assign slot_sum = div_rem + base;
  assign slot_c   = (div_rem < SW'(sp) && div_st.odd) ? slot_sum[AW-1:0] : div_rem[AW-1:0];
  assign fill_eff = fill_rv ? fill_rd : '0;
  assign load_w   = 64'(count) * 64'd10;
  assign cap_w    = 64'(prod) << 3;
  assign items_w  = 64'(count);
  assign slots_w  = 64'(used);
  assign req.ready = (state == S_IDLE);

  function automatic logic [MW-1:0] ent_addr(input logic [AW-1:0] s, input logic [FW-1:0] e);
    ent_addr = MW'(32'(s) * SLOT_DEPTH + 32'(e));
  endfunction

  always_comb begin
    div_start  = 1'b0;
    div_dvd    = key_q;
    ent_re     = 1'b0;
    ent_raddr  = ent_addr(slot_q, eidx);
    ent_we     = 1'b0;
    ent_waddr  = ent_addr(slot_q, fill_q);
    ent_wkey   = key_q;
    ent_wdat   = data_q;
    fill_raddr = slot_c;
    fill_we    = 1'b0;
    fill_waddr = slot_q;
    fill_wdata = fill_q + 1'b1;
    case (state)
      S_SPL:   fill_raddr = sp;
      S_SRD:   begin
        ent_re    = (eidx != nfill);
        ent_raddr = ent_addr(old_s, eidx);
      end
      S_SRDW:  begin
        div_start = 1'b1;
        div_dvd   = rd_key;
      end
      S_SDIV:  begin
        ent_wkey = rd_key;
        ent_wdat = rd_dat;
        if (div_st.done) begin
          if (slot_c == old_s) begin
            ent_we    = 1'b1;
            ent_waddr = ent_addr(old_s, keep);
          end else if (fcnt < FW'(SLOT_DEPTH)) begin
            ent_we    = 1'b1;
            ent_waddr = ent_addr(fresh_s, fcnt);
          end
        end
      end
      S_SWO:   begin
        fill_we    = 1'b1;
        fill_waddr = old_s;
        fill_wdata = keep;
      end
      S_SWN:   begin
        fill_we    = 1'b1;
        fill_waddr = fresh_s;
        fill_wdata = fcnt;
      end
      S_HASH:  div_start = 1'b1;
      S_SCAN:  begin
        ent_re = (eidx != fill_q);
        if (eidx == fill_q && op == OP_INSERT && fill_q < FW'(SLOT_DEPTH)) begin
          ent_we  = 1'b1;
          fill_we = 1'b1;
        end
      end
      S_SCANW: begin
        ent_re    = (rd_key == key_q) && (op == OP_REMOVE);
        ent_raddr = ent_addr(slot_q, fill_q - 1'b1);
      end
      S_RMB:   begin
        ent_we     = 1'b1;
        ent_waddr  = ent_addr(slot_q, eidx);
        ent_wkey   = rd_key;
        ent_wdat   = rd_dat;
        fill_we    = 1'b1;
        fill_wdata = fill_q - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_key[ent_waddr] <= ent_wkey;
      ent_dat[ent_waddr] <= ent_wdat;
    end
    if (ent_re) begin
      rd_key <= ent_key[ent_raddr];
      rd_dat <= ent_dat[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
    fill_rd <= fill_mem[fill_raddr];
  end

  assign fill_clr = (state == S_IDLE) && req.valid &&
                    (req.operation == OP_CREATE || req.operation == OP_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_valid <= '0;
      fill_rv    <= 1'b0;
    end else begin
      fill_rv <= fill_valid[fill_raddr];
      if (fill_clr) fill_valid <= '0;
      else if (fill_we) fill_valid[fill_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= SW'(BASE_RESET);
      sp        <= '0;
      count     <= '0;
      ibk       <= IBK_RESET;
      bsz       <= BSZ_RESET;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_write && cfg_index == REG_INIT_BUCKETS) ibk <= cfg_data[IBK_W-1:0];
      if (cfg_write && cfg_index == REG_BUCKET_SIZE)  bsz <= cfg_data[BSZ_W-1:0];
      // the response state reloads valid itself
      if (rsp.valid && rsp.ready && state != S_RESP) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op       <= req.operation;
            key_q    <= req.key;
            data_q   <= req.data_in;
            status_q <= ST_OK;
            dout_q   <= '0;
            state    <= S_RESP;
            case (req.operation)
              OP_CREATE: begin
                if (ibk == '0) base <= SW'(1);
                else if (32'(ibk) > 32'(MAX_SLOTS)) base <= SW'(MAX_SLOTS);
                else base <= SW'(ibk);
                sp    <= '0;
                count <= '0;
              end
              OP_CLEAR:  count <= '0;
              OP_INSERT: begin
                count <= count + 1'b1;
                state <= S_THR;
              end
              OP_GET, OP_REMOVE: state <= S_HASH;
              OP_GROW:   state <= S_SPL;
              default: ;
            endcase
          end
        end
        S_THR: begin
          prod  <= PW'(used) * PW'(bsz);
          state <= S_CMP;
        end
        S_CMP: state <= (load_w > cap_w) ? S_SPL : S_HASH;
        S_SPL: begin
          if (32'(used) >= 32'(MAX_SLOTS)) begin
            if (op == OP_GROW) begin
              status_q <= ST_NOSPACE;
              state    <= S_RESP;
            end else begin
              state <= S_HASH;
            end
          end else begin
            old_s   <= sp;
            fresh_s <= used[AW-1:0];
            if (sp_inc >= base) begin
              base <= base << 1;
              sp   <= '0;
            end else begin
              sp <= sp_inc[AW-1:0];
            end
            state <= S_SFIL;
          end
        end
        S_SFIL: begin
          nfill <= (fill_eff > FW'(SLOT_DEPTH)) ? FW'(SLOT_DEPTH) : fill_eff;
          eidx  <= '0;
          keep  <= '0;
          fcnt  <= '0;
          state <= S_SRD;
        end
        S_SRD:  state <= (eidx == nfill) ? S_SWO : S_SRDW;
        S_SRDW: state <= S_SDIV;
        S_SDIV: begin
          if (div_st.done) begin
            if (slot_c == old_s) keep <= keep + 1'b1;
            else if (fcnt < FW'(SLOT_DEPTH)) fcnt <= fcnt + 1'b1;
            eidx  <= eidx + 1'b1;
            state <= S_SRD;
          end
        end
        S_SWO: state <= S_SWN;
        S_SWN: state <= (op == OP_GROW) ? S_RESP : S_HASH;
        S_HASH: state <= S_HASHW;
        S_HASHW: begin
          if (div_st.done) begin
            slot_q <= slot_c;
            state  <= S_FILW;
          end
        end
        S_FILW: begin
          fill_q <= fill_eff;
          eidx   <= '0;
          state  <= S_SCAN;
        end
        S_SCAN: begin
          if (eidx == fill_q) begin
            state <= S_RESP;
            if (op == OP_INSERT) begin
              if (fill_q >= FW'(SLOT_DEPTH)) begin
                status_q <= ST_NOSPACE;
                count    <= count - 1'b1;
              end
            end else begin
              status_q <= ST_MISS;
            end
          end else begin
            state <= S_SCANW;
          end
        end
        S_SCANW: begin
          if (rd_key == key_q) begin
            state <= S_RESP;
            if (op == OP_INSERT) begin
              status_q <= ST_DUP;
              count    <= count - 1'b1;
            end else begin
              dout_q <= rd_dat;
              if (op == OP_REMOVE) state <= S_RMB;
            end
          end else begin
            eidx  <= eidx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_RMB: begin
          if (count != '0) count <= count - 1'b1;
          state <= S_RESP;
        end
        S_RESP: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.status     <= status_q;
            rsp.data_out   <= dout_q;
            rsp.item_total <= items_w[ITEMS_W-1:0];
            rsp.slot_total <= slots_w[SLOTS_W-1:0];
            state          <= S_IDLE;
          end else begin
            rsp.valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LHT_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready held after accept")
  `LHT_ASSERT_NOW(a_pointer_below_base, 1'b1, SW'(sp) < base && base != '0, "split pointer out of range")
  `LHT_ASSERT_NOW(a_slots_bounded, 1'b1, 32'(used) <= 32'(MAX_SLOTS), "slot count above limit")
  `LHT_ASSERT_NOW(a_rsp_from_resp, $rose(rsp.valid), $past(state) == S_RESP, "response outside resp state")

endmodule

// File: tb/lht_checker.sv
// Response checker for the linear hash table engine: table model plus in-order compare.
`timescale 1ns / 1ps
module lht_checker (
  input  logic                          clk,
  input  logic                          rst,
  lht_req_if                            req,
  lht_rsp_if                            rsp,
  input  logic                          cfg_write,
  input  logic [lht_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lht_pkg::CFG_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending
);
  import lht_pkg::*;

  localparam int NSLOT = MAX_SLOTS_DEF;
  localparam int DEPTH = SLOT_DEPTH_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic [ITEMS_W-1:0]  item_total;
    logic [SLOTS_W-1:0]  slot_total;
  } lht_rsp_t;

  lht_rsp_t          rsp_fifo[$];
  logic [KEY_W-1:0]  tbl_key[NSLOT*DEPTH];
  logic [DATA_W-1:0] tbl_data[NSLOT*DEPTH];
  int unsigned       fill[NSLOT];
  int unsigned       base_cnt, split_ptr, items;
  logic [IBK_W-1:0]  init_bkt;
  logic [BSZ_W-1:0]  bkt_size;

  assign pending = rsp_fifo.size();

  function automatic int unsigned home_slot(logic [KEY_W-1:0] k);
    longint unsigned n, idx;
    n = (base_cnt == 0) ? 1 : base_cnt;
    idx = k % n;
    if (idx < split_ptr) idx = k % (2 * n);
    return 32'(idx % NSLOT);
  endfunction

  function automatic int find_key(int unsigned s, logic [KEY_W-1:0] k);
    for (int e = 0; e < fill[s] && e < DEPTH; e++)
      if (tbl_key[s*DEPTH+e] == k) return e;
    return DEPTH;
  endfunction

  function automatic bit split_one();
    int unsigned old, fresh, keep, cnt, src, dst;
    if (base_cnt + split_ptr >= NSLOT) return 0;
    old = split_ptr;
    fresh = base_cnt + split_ptr;
    keep = 0;
    split_ptr++;
    if (split_ptr >= base_cnt) begin
      base_cnt *= 2;
      split_ptr = 0;
    end
    fill[fresh] = 0;
    cnt = (fill[old] > DEPTH) ? DEPTH : fill[old];
    for (int e = 0; e < cnt; e++) begin
      src = old*DEPTH + e;
      if (home_slot(tbl_key[src]) == old) begin
        tbl_key[old*DEPTH+keep] = tbl_key[src];
        tbl_data[old*DEPTH+keep] = tbl_data[src];
        keep++;
      end else if (fill[fresh] < DEPTH) begin
        dst = fresh*DEPTH + fill[fresh];
        tbl_key[dst] = tbl_key[src];
        tbl_data[dst] = tbl_data[src];
        fill[fresh]++;
      end
    end
    fill[old] = keep;
    return 1;
  endfunction

  function automatic void empty_all();
    foreach (fill[i]) fill[i] = 0;
    items = 0;
  endfunction

  function automatic lht_rsp_t apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                        logic [DATA_W-1:0] d);
    lht_rsp_t r;
    int unsigned s, last;
    int pos;
    longint unsigned load, cap;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_CREATE: begin
        base_cnt = (init_bkt == 0) ? 1 : (init_bkt > NSLOT) ? NSLOT : init_bkt;
        split_ptr = 0;
        empty_all();
      end
      OP_INSERT: begin
        items++;
        load = items * 10;
        cap = 8 * (base_cnt + split_ptr) * bkt_size;
        if (load > cap) void'(split_one());
        s = home_slot(k);
        if (find_key(s, k) < DEPTH) begin
          r.status = ST_DUP;
          items--;
        end else if (fill[s] >= DEPTH) begin
          r.status = ST_NOSPACE;
          items--;
        end else begin
          tbl_key[s*DEPTH+fill[s]] = k;
          tbl_data[s*DEPTH+fill[s]] = d;
          fill[s]++;
        end
      end
      OP_GET: begin
        s = home_slot(k);
        pos = find_key(s, k);
        if (pos < DEPTH) r.data_out = tbl_data[s*DEPTH+pos];
        else r.status = ST_MISS;
      end
      OP_REMOVE: begin
        s = home_slot(k);
        pos = find_key(s, k);
        if (pos < DEPTH) begin
          last = s*DEPTH + fill[s] - 1;
          r.data_out = tbl_data[s*DEPTH+pos];
          tbl_key[s*DEPTH+pos] = tbl_key[last];
          tbl_data[s*DEPTH+pos] = tbl_data[last];
          fill[s]--;
          if (items > 0) items--;
        end else begin
          r.status = ST_MISS;
        end
      end
      OP_CLEAR: empty_all();
      OP_GROW: if (!split_one()) r.status = ST_NOSPACE;
      default: ;
    endcase
    r.item_total = items[ITEMS_W-1:0];
    r.slot_total = SLOTS_W'(base_cnt + split_ptr);
    return r;
  endfunction

  task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    lht_rsp_t want;
    if (rst) begin
      errors = 0;
      rsp_fifo.delete();
      empty_all();
      base_cnt = 32;
      split_ptr = 0;
      init_bkt = IBK_RESET;
      bkt_size = BSZ_RESET;
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_INIT_BUCKETS) init_bkt = cfg_data[IBK_W-1:0];
        else bkt_size = cfg_data[BSZ_W-1:0];
      end
      if (req.valid && req.ready)
        rsp_fifo.push_back(apply_op(req.operation, req.key, req.data_in));
      if (rsp.valid && rsp.ready) begin
        if (rsp_fifo.size() == 0) begin
          report("unexpected response beat, status", DATA_W'(rsp.status), '0);
        end else begin
          want = rsp_fifo.pop_front();
          if (rsp.status !== want.status)
            report("status", DATA_W'(rsp.status), DATA_W'(want.status));
          if (rsp.data_out !== want.data_out) report("data_out", rsp.data_out, want.data_out);
          if (rsp.item_total !== want.item_total)
            report("item_total", DATA_W'(rsp.item_total), DATA_W'(want.item_total));
          if (rsp.slot_total !== want.slot_total)
            report("slot_total", DATA_W'(rsp.slot_total), DATA_W'(want.slot_total));
        end
      end
    end
  end
endmodule

// File: tb/tb.sv
// Top of the hash table engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb;
  import lht_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  int errors, pending;
  int idle_cycles = 0;
  bit long_hold = 0;
  int phase_no = 0;
  logic [KEY_W-1:0] key_pool[48];

  lht_req_if req ();
  lht_rsp_if rsp ();

  linear_hash_table_engine dut (
    .clk, .rst, .req(req.sink), .rsp(rsp.source), .cfg_write, .cfg_index, .cfg_data
  );

  lht_checker chk (
    .clk, .rst, .req, .rsp, .cfg_write, .cfg_index, .cfg_data, .errors, .pending
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // receiver: own stall pattern, plus one long hold-off
  always @(posedge clk) begin
    if (long_hold) rsp.ready <= 0;
    else if (phase_no % 3 == 0) rsp.ready <= 1;
    else rsp.ready <= ($urandom_range(0, 3) != 0);
  end

  initial begin
    wait (phase_no == 2);
    @(posedge clk);
    long_hold <= 1;
    repeat (800) @(posedge clk);
    long_hold <= 0;
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 30000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_beat(logic [OP_W-1:0] op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
    bit took;
    req.valid <= 1;
    req.operation <= op;
    req.key <= k;
    req.data_in <= d;
    do begin
      @(negedge clk);
      took = req.ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic pause(int n);
    req.valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_and_config(logic [IBK_W-1:0] ib, logic [BSZ_W-1:0] bs);
    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    cfg_write <= 1;
    cfg_index <= REG_INIT_BUCKETS;
    cfg_data <= CFG_W'(ib);
    @(posedge clk);
    cfg_index <= REG_BUCKET_SIZE;
    cfg_data <= CFG_W'(bs);
    @(posedge clk);
    cfg_write <= 0;
  endtask

  function automatic logic [OP_W-1:0] pick_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return OP_INSERT;
    if (r < 60) return OP_GET;
    if (r < 80) return OP_REMOVE;
    if (r < 89) return OP_GROW;
    if (r < 92) return OP_CLEAR;
    if (r < 95) return OP_CREATE;
    return OP_W'($urandom_range(6, 7));
  endfunction

  initial begin
    logic [IBK_W-1:0] ibs[9] = '{32, 0, 511, 256, 1, 2, 4, 300, 8};
    logic [BSZ_W-1:0] bss[9] = '{8, 64, 1, 8, 0, 127, 3, 16, 2};
    logic [KEY_W-1:0] k;
    int burst;
    req.valid <= 0;
    req.operation <= '0;
    req.key <= '0;
    req.data_in <= '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    drain_and_config(ibs[0], bss[0]);

    // directed: fill one slot past its depth, then every operation and miss
    send_beat(OP_CREATE, 0, 32'hFFFF_FFFF);
    for (int i = 0; i < 17; i++) send_beat(OP_INSERT, KEY_W'(i) << 10, $urandom);
    send_beat(OP_INSERT, 32'h0000_0400, 32'hFFFF_FFFF);
    send_beat(OP_GET, 32'h0000_0800, 0);
    send_beat(OP_GET, 32'hFFFF_FFFF, 0);
    send_beat(OP_REMOVE, 32'h0000_0000, 0);
    send_beat(OP_REMOVE, 32'hFFFF_FFFF, 0);
    send_beat(OP_GROW, 0, 0);
    send_beat(OP_CLEAR, 0, 0);
    send_beat(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(3'd7, 0, 0);

    for (int p = 0; p < 9; p++) begin
      if (p > 0) drain_and_config(ibs[p], bss[p]);
      phase_no <= p;
      foreach (key_pool[i])
        key_pool[i] = (i < 16) ? KEY_W'($urandom_range(0, 600)) : KEY_W'($urandom);
      send_beat(OP_CREATE, $urandom, $urandom);
      for (int n = 0; n < 170; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst; b++, n++) begin
          k = ($urandom_range(0, 9) == 0) ? KEY_W'($urandom) : key_pool[$urandom_range(0, 47)];
          send_beat(pick_op(), k, $urandom);
        end
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 90));
      end
    end

    req.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// File: linear_hash_table_engine.f
+incdir+rtl
rtl/lht_pkg.sv
rtl/lht_if.sv
rtl/lht_div.sv
rtl/linear_hash_table_engine.sv
tb/lht_checker.sv
tb/tb.sv
